[design/spjq_pkg.sv]
// ----------------------------------------------------------------------------
// spjq_pkg: shared types and constants of the stable priority job queue
// Job entry layout, result status codes, controller states and the command
// and status bundles that pass between controller and datapath.
// ----------------------------------------------------------------------------
package spjq_pkg;

  localparam int unsigned IdW     = 16;
  localparam int unsigned PrioW   = 2;
  localparam int unsigned BurstW  = 16;
  localparam int unsigned FinishW = 22;
  localparam int unsigned AddrW   = 32;

  // First block address after reset and the step per served job
  localparam logic [AddrW-1:0] BlockBase = 32'd1000;
  localparam logic [AddrW-1:0] BlockStep = 32'd100;

  // One stored job
  typedef struct packed {
    logic [IdW-1:0]    id;
    logic [PrioW-1:0]  prio;
    logic [BurstW-1:0] burst;
  } job_t;

  // Result status codes
  typedef enum logic [1:0] {
    StAccepted = 2'd0,
    StFull     = 2'd1,
    StEmpty    = 2'd2,
    StServed   = 2'd3
  } status_e;

  // Item kinds
  typedef enum logic {
    KindEnqueue = 1'b0,
    KindDrain   = 1'b1
  } kind_e;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_INSERT,
    S_DRAIN
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic latch_job;   // capture the incoming job
    logic ins_init;    // start the downward insertion walk at the top
    logic ins_shift;   // move one entry up by one slot
    logic ins_place;   // write the new job into the freed slot
    logic drain_init;  // start serving from the head
    logic drain_step;  // serve one entry
    logic emit_full;   // report queue full
    logic emit_empty;  // report queue empty
  } ctrl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic count_zero;
    logic full;
    logic ins_done;    // walk reached the bottom, or slot below holds a job of equal or more urgent priority
    logic drain_last;  // entry being served is the final one
  } ctrl_stat_t;

endpackage

[design/stable_priority_job_queue_core.sv]
// Enqueue: busy while the k stored jobs of less urgent priority move up one
//   slot each cycle and while the job is placed; the result word is registered.
// Drain of n jobs: busy for its n drain steps, one served word per cycle; the
//   first passes the store read and result registers. Full or empty: one word,
//   registered from the start cycle. The single write port paces the walk.
// Reset clears the queue and sets the block address to 1000; no results stall.
// ----------------------------------------------------------------------------
// stable_priority_job_queue_core: stable four-level priority job queue
// Inserts jobs in priority order, first in first out among equals, and
// serves the whole queue on a drain command with finish time and block address.
// ----------------------------------------------------------------------------
module stable_priority_job_queue_core #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic                              kind_i,
  input  logic [spjq_pkg::IdW-1:0]          job_id_i,
  input  logic [spjq_pkg::PrioW-1:0]        job_priority_i,
  input  logic [spjq_pkg::BurstW-1:0]       job_burst_i,
  output logic                              result_valid_o,
  output logic [1:0]                        status_o,
  output logic [spjq_pkg::IdW-1:0]          served_id_o,
  output logic [spjq_pkg::PrioW-1:0]        served_priority_o,
  output logic [spjq_pkg::BurstW-1:0]       served_burst_o,
  output logic [spjq_pkg::FinishW-1:0]      finish_time_o,
  output logic [spjq_pkg::AddrW-1:0]        block_address_o,
  output logic                              last_o
);

  spjq_pkg::ctrl_cmd_t  cmd;
  spjq_pkg::ctrl_stat_t stat;

  // Sequencer
  spjq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .kind_i  (kind_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  // Store and result path
  spjq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .job_id_i          (job_id_i),
    .job_priority_i    (job_priority_i),
    .job_burst_i       (job_burst_i),
    .result_valid_o    (result_valid_o),
    .status_o          (status_o),
    .served_id_o       (served_id_o),
    .served_priority_o (served_priority_o),
    .served_burst_o    (served_burst_o),
    .finish_time_o     (finish_time_o),
    .block_address_o   (block_address_o),
    .last_o            (last_o)
  );

  // A served word only ever comes out of a drain in progress
  a_served_from_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (status_o == spjq_pkg::StServed) |-> $past(busy))
    else $error("served word without a drain in progress");

  // An enqueue into a full queue is refused in the next cycle
  a_full_refused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (kind_i == spjq_pkg::KindEnqueue) && stat.full
    |=> result_valid_o && (status_o == spjq_pkg::StFull) && last_o)
    else $error("full queue did not refuse the job");

  // The final served word leaves the queue empty
  a_drain_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (status_o == spjq_pkg::StServed) && last_o
    |-> stat.count_zero && !busy)
    else $error("queue not empty after final served word");

  // Shift and place never coincide with a drain step
  a_cmd_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({cmd.ins_shift, cmd.ins_place, cmd.drain_step,
                cmd.emit_full, cmd.emit_empty}) <= 1)
    else $error("conflicting datapath commands");

endmodule

[design/spjq_ctrl.sv]
// ----------------------------------------------------------------------------
// spjq_ctrl: sequencer of the job queue
// Accepts a word, then steps the datapath through a sorted insertion walk or
// a drain of every stored job, or has a full or empty status reported.
// ----------------------------------------------------------------------------
module spjq_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic                   kind_i,
  input  spjq_pkg::ctrl_stat_t   stat_i,
  output spjq_pkg::ctrl_cmd_t    cmd_o,
  output logic                   busy_o
);

  spjq_pkg::state_e state_q, state_d;
  logic             accept;

  assign accept = start_i && (state_q == spjq_pkg::S_IDLE);
  assign busy_o = (state_q != spjq_pkg::S_IDLE);

  // Hold the state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= spjq_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      spjq_pkg::S_IDLE: begin
        if (accept) begin
          if (kind_i == spjq_pkg::KindEnqueue) begin
            if (!stat_i.full) state_d = spjq_pkg::S_INSERT;
          end else begin
            if (!stat_i.count_zero) state_d = spjq_pkg::S_DRAIN;
          end
        end
      end
      spjq_pkg::S_INSERT: begin
        if (stat_i.ins_done) state_d = spjq_pkg::S_IDLE;
      end
      spjq_pkg::S_DRAIN: begin
        if (stat_i.drain_last) state_d = spjq_pkg::S_IDLE;
      end
      default: state_d = spjq_pkg::S_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      spjq_pkg::S_IDLE: begin
        if (accept) begin
          if (kind_i == spjq_pkg::KindEnqueue) begin
            if (stat_i.full) begin
              cmd_o.emit_full = 1'b1;
            end else begin
              cmd_o.latch_job = 1'b1;
              cmd_o.ins_init  = 1'b1;
            end
          end else begin
            if (stat_i.count_zero) begin
              cmd_o.emit_empty = 1'b1;
            end else begin
              cmd_o.drain_init = 1'b1;
            end
          end
        end
      end
      spjq_pkg::S_INSERT: begin
        if (stat_i.ins_done) begin
          cmd_o.ins_place = 1'b1;
        end else begin
          cmd_o.ins_shift = 1'b1;
        end
      end
      spjq_pkg::S_DRAIN: begin
        cmd_o.drain_step = 1'b1;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

[design/spjq_datapath.sv]
// ----------------------------------------------------------------------------
// spjq_datapath: job store, counters and result registers
// Keeps the jobs sorted by priority in a single-port-write memory, moves one
// entry per cycle during insertion and serves one entry per cycle on drain.
// ----------------------------------------------------------------------------
module spjq_datapath #(
  parameter int unsigned CAPACITY = 32,
  localparam int unsigned AW = $clog2(CAPACITY),
  localparam int unsigned CW = $clog2(CAPACITY + 1)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  spjq_pkg::ctrl_cmd_t               cmd_i,
  output spjq_pkg::ctrl_stat_t              stat_o,
  input  logic [spjq_pkg::IdW-1:0]          job_id_i,
  input  logic [spjq_pkg::PrioW-1:0]        job_priority_i,
  input  logic [spjq_pkg::BurstW-1:0]       job_burst_i,
  output logic                              result_valid_o,
  output logic [1:0]                        status_o,
  output logic [spjq_pkg::IdW-1:0]          served_id_o,
  output logic [spjq_pkg::PrioW-1:0]        served_priority_o,
  output logic [spjq_pkg::BurstW-1:0]       served_burst_o,
  output logic [spjq_pkg::FinishW-1:0]      finish_time_o,
  output logic [spjq_pkg::AddrW-1:0]        block_address_o,
  output logic                              last_o
);

  spjq_pkg::job_t mem [CAPACITY];
  spjq_pkg::job_t rd_q;
  spjq_pkg::job_t job_q;

  logic [CW-1:0]                   count_q, count_d;
  logic [CW-1:0]                   ptr_q, ptr_d;
  logic [spjq_pkg::FinishW-1:0]    clock_q, clock_d;
  logic [spjq_pkg::AddrW-1:0]      block_q, block_d;

  logic [CW-1:0]                   rd_ptr;
  logic [AW-1:0]                   rd_addr;
  logic                            mem_we;
  spjq_pkg::job_t                  wr_data;

  logic                            out_valid_q, out_valid_d;
  spjq_pkg::status_e               out_status_q, out_status_d;
  spjq_pkg::job_t                  out_job_q, out_job_d;
  logic [spjq_pkg::FinishW-1:0]    out_finish_q, out_finish_d;
  logic [spjq_pkg::AddrW-1:0]      out_block_q, out_block_d;
  logic                            out_last_q, out_last_d;

  // Status towards the controller
  assign stat_o.count_zero = (count_q == '0);
  assign stat_o.full       = (count_q == CW'(CAPACITY));
  assign stat_o.ins_done   = (ptr_q == '0) || (rd_q.prio <= job_q.prio);
  assign stat_o.drain_last = (ptr_q == (count_q - CW'(1)));

  // Read address: the entry needed in the following cycle
  always_comb begin
    rd_ptr = '0;
    if (cmd_i.ins_init) begin
      rd_ptr = count_q - CW'(1);
    end else if (cmd_i.ins_shift) begin
      rd_ptr = ptr_q - CW'(2);
    end else if (cmd_i.drain_step) begin
      rd_ptr = ptr_q + CW'(1);
    end
  end
  assign rd_addr = rd_ptr[AW-1:0];

  // Write: shift the entry below up, or place the new job
  assign mem_we  = cmd_i.ins_shift || cmd_i.ins_place;
  assign wr_data = cmd_i.ins_place ? job_q : rd_q;

  // Job store
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[ptr_q[AW-1:0]] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  // Capture the incoming job
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_job) begin
      job_q <= '{id: job_id_i, prio: job_priority_i, burst: job_burst_i};
    end
  end

  // Counters and walk pointer
  always_comb begin
    count_d = count_q;
    ptr_d   = ptr_q;
    clock_d = clock_q;
    block_d = block_q;
    if (cmd_i.ins_init) begin
      ptr_d = count_q;
    end
    if (cmd_i.ins_shift) begin
      ptr_d = ptr_q - CW'(1);
    end
    if (cmd_i.ins_place) begin
      count_d = count_q + CW'(1);
    end
    if (cmd_i.drain_init) begin
      ptr_d   = '0;
      clock_d = '0;
    end
    if (cmd_i.drain_step) begin
      ptr_d   = ptr_q + CW'(1);
      clock_d = clock_q + spjq_pkg::FinishW'(rd_q.burst);
      block_d = block_q + spjq_pkg::BlockStep;
      if (stat_o.drain_last) count_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ptr_q   <= '0;
      clock_q <= '0;
      block_q <= spjq_pkg::BlockBase;
    end else begin
      count_q <= count_d;
      ptr_q   <= ptr_d;
      clock_q <= clock_d;
      block_q <= block_d;
    end
  end

  // Result word
  always_comb begin
    out_valid_d  = 1'b0;
    out_status_d = spjq_pkg::StAccepted;
    out_job_d    = '0;
    out_finish_d = '0;
    out_block_d  = '0;
    out_last_d   = 1'b1;
    if (cmd_i.emit_full) begin
      out_valid_d  = 1'b1;
      out_status_d = spjq_pkg::StFull;
    end else if (cmd_i.emit_empty) begin
      out_valid_d  = 1'b1;
      out_status_d = spjq_pkg::StEmpty;
    end else if (cmd_i.ins_place) begin
      out_valid_d  = 1'b1;
      out_status_d = spjq_pkg::StAccepted;
    end else if (cmd_i.drain_step) begin
      out_valid_d  = 1'b1;
      out_status_d = spjq_pkg::StServed;
      out_job_d    = rd_q;
      out_finish_d = clock_d;
      out_block_d  = block_q;
      out_last_d   = stat_o.drain_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_status_q <= out_status_d;
    out_job_q    <= out_job_d;
    out_finish_q <= out_finish_d;
    out_block_q  <= out_block_d;
    out_last_q   <= out_last_d;
  end

  assign result_valid_o    = out_valid_q;
  assign status_o          = out_status_q;
  assign served_id_o       = out_job_q.id;
  assign served_priority_o = out_job_q.prio;
  assign served_burst_o    = out_job_q.burst;
  assign finish_time_o     = out_finish_q;
  assign block_address_o   = out_block_q;
  assign last_o            = out_last_q;

endmodule
